// ===== src/lls_pkg.sv =====
// lls_pkg: shared types and constants for the luma laplacian sharpener
`timescale 1ns / 1ps
`default_nettype none

package lls_pkg;

  // input word
  typedef struct packed {
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  // output word
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;
  } pix_out_t;

  // per-word control carried from the accept stage to the line read stage
  typedef struct packed {
    logic is_pix;
    logic emit;
    logic border;
    logic use_mid;
    logic frame_end;
  } s1_ctl_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_KERNEL_SELECT = 2'd2;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd768;

  // luma coefficients, q16
  localparam logic [16:0] LUMA_R = 17'd19589;
  localparam logic [16:0] LUMA_G = 17'd38443;
  localparam logic [16:0] LUMA_B = 17'd7504;

  // back conversion coefficients, q16
  localparam logic signed [18:0] CR_TO_R = 19'sd91881;
  localparam logic signed [18:0] CB_TO_G = 19'sd22553;
  localparam logic signed [18:0] CR_TO_G = 19'sd46802;
  localparam logic signed [18:0] CB_TO_B = 19'sd116130;

  function automatic logic [7:0] luma_of(input logic [23:0] pix);
    logic [25:0] acc;
    acc = 26'(LUMA_R) * 26'(pix[23:16]) + 26'(LUMA_G) * 26'(pix[15:8])
        + 26'(LUMA_B) * 26'(pix[7:0]);
    return acc[23:16];
  endfunction

endpackage

`default_nettype wire

// ===== src/luma_laplacian_sharpen_3x3.sv =====
// luma_laplacian_sharpen_3x3: streaming rgb sharpener on luma with two line memories
//
// channel | valid     | stall     | word
// input   | src_valid | src_stall | src_word (pix_in_t)
// output  | dst_valid | dst_stall | dst_word (pix_out_t)
// config  | cfg_write | -         | cfg_index, cfg_data
//
// one word per cycle while the output is not stalled; an accepted word passes s1 to s5 and the output register
// the two line memories are read on accept and written back as the word leaves stage 1,
// so a single read and a single write port per memory set the rate
// reset is synchronous; line memories are not cleared, the first rows only
// reach window places whose results are never used
// a stalled output holds the pipe only where a stage ahead is full
`timescale 1ns / 1ps
`default_nettype none

module luma_laplacian_sharpen_3x3
  import lls_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     src_valid,
  output logic          src_stall,
  input  wire pix_in_t  src_word,
  output logic          dst_valid,
  input  wire logic     dst_stall,
  output pix_out_t      dst_word,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = CW + 1;
  localparam int CMPW = (WW > 11) ? WW : 11;

  // configuration
  logic [10:0] frame_width;
  logic [11:0] frame_height;
  logic        kernel_select;

  // frame position
  logic [CW-1:0] col;
  logic [11:0]   row;
  logic          done;
  logic [CW-1:0] fcol;
  logic          flast;
  logic          fstarted;

  // effective geometry
  logic [CMPW-1:0] fw_ext;
  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   w_last;
  logic [11:0]     h_eff;
  logic [11:0]     h_last;

  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (frame_width == 11'd0) begin
      w_eff = WW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_ext);
    end
    w_last = w_eff - WW'(1);
    h_eff  = (frame_height == 12'd0) ? 12'd1 : frame_height;
    h_last = h_eff - 12'd1;
  end

  // pipeline enables
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, out_ready;
  assign out_ready = !dst_valid || !dst_stall;
  assign en5 = !v5 || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign src_stall = !en1;

  logic acc;
  assign acc = src_valid && en1;

  // accept stage decode
  logic          is_pix_in;
  logic          real_in;
  logic [CW-1:0] fcol_cur;
  logic          flast_cur;
  logic          col_wrap;
  logic          fcol_wrap;
  logic          flush_end;
  s1_ctl_t       ctl_in;
  logic [CW-1:0] addr_in;

  always_comb begin
    is_pix_in = (src_word.op == OP_PIXEL);
    fcol_cur  = fstarted ? fcol : ((h_eff == 12'd1) ? '0 : CW'(w_last));
    flast_cur = fstarted ? flast : (h_eff == 12'd1);
    col_wrap  = ({1'b0, col} == w_last);
    fcol_wrap = ({1'b0, fcol_cur} == w_last);
    flush_end = flast_cur && fcol_wrap;
    real_in   = is_pix_in ? !done : done;
    ctl_in.is_pix    = is_pix_in;
    ctl_in.emit      = is_pix_in ? ((row >= 12'd2) || (row == 12'd1 && col != '0)) : 1'b1;
    ctl_in.border    = is_pix_in ? ((col[CW-1:1] == '0) || (row == 12'd1)) : 1'b1;
    ctl_in.use_mid   = flast_cur;
    ctl_in.frame_end = !is_pix_in && flush_end;
    addr_in          = is_pix_in ? col : fcol_cur;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      kernel_select <= 1'b0;
      col      <= '0;
      row      <= '0;
      done     <= 1'b0;
      fcol     <= '0;
      flast    <= 1'b0;
      fstarted <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[10:0];
          col <= '0; row <= '0; done <= 1'b0; fstarted <= 1'b0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          col <= '0; row <= '0; done <= 1'b0; fstarted <= 1'b0;
        end
        REG_KERNEL_SELECT: begin
          kernel_select <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else if (acc && real_in) begin
      if (is_pix_in) begin
        if (col_wrap) begin
          col <= '0;
          if (row == h_last) begin
            done <= 1'b1;
          end else begin
            row <= row + 12'd1;
          end
        end else begin
          col <= col + CW'(1);
        end
      end else if (flush_end) begin
        col <= '0; row <= '0; done <= 1'b0; fstarted <= 1'b0;
      end else begin
        fstarted <= 1'b1;
        if (fcol_wrap) begin
          fcol  <= '0;
          flast <= 1'b1;
        end else begin
          fcol  <= fcol_cur + CW'(1);
          flast <= flast_cur;
        end
      end
    end
  end

  // stage 1: line memory data
  s1_ctl_t       s1_ctl;
  logic [CW-1:0] s1_addr;
  logic [23:0]   s1_pix;

  logic [23:0] upper_row_store  [MAX_WIDTH];
  logic [23:0] middle_row_store [MAX_WIDTH];
  logic [23:0] up_q, mid_q;
  logic        fwd;
  logic [23:0] fwd_up, fwd_mid;

  logic [23:0] up_rd, mid_rd, sel_rd;
  logic        mem_we;
  logic        mv1;

  assign up_rd  = fwd ? fwd_up : up_q;
  assign mid_rd = fwd ? fwd_mid : mid_q;
  assign sel_rd = s1_ctl.use_mid ? mid_rd : up_rd;
  assign mv1    = v1 && en2;
  assign mem_we = mv1 && s1_ctl.is_pix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_row_store[s1_addr]  <= mid_rd;
      middle_row_store[s1_addr] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      up_q    <= upper_row_store[addr_in];
      mid_q   <= middle_row_store[addr_in];
      fwd_up  <= mid_rd;
      fwd_mid <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (acc) begin
      // write of the word ahead lands on the entry being read
      fwd <= mem_we && (s1_addr == addr_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= acc && real_in;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl  <= ctl_in;
      s1_addr <= addr_in;
      s1_pix  <= {src_word.red_in, src_word.green_in, src_word.blue_in};
    end
  end

  // luma window; index 3*row + column, column 2 newest
  logic [7:0]  lw [9];
  logic [23:0] cm2;

  always_ff @(posedge clk) begin
    if (mv1 && s1_ctl.is_pix) begin
      lw[0] <= lw[1]; lw[1] <= lw[2]; lw[2] <= luma_of(up_rd);
      lw[3] <= lw[4]; lw[4] <= lw[5]; lw[5] <= luma_of(mid_rd);
      lw[6] <= lw[7]; lw[7] <= lw[8]; lw[8] <= luma_of(s1_pix);
      cm2 <= mid_rd;
    end
  end

  // stage 2: kernel
  logic [23:0] s2_rgb;
  logic [7:0]  s2_y;
  logic        s2_border;
  logic        s2_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1 && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_rgb    <= s1_ctl.is_pix ? cm2 : sel_rd;
      s2_y      <= s1_ctl.is_pix ? lw[5] : luma_of(sel_rd);
      s2_border <= s1_ctl.border;
      s2_fe     <= s1_ctl.frame_end;
    end
  end

  logic signed [12:0] ksum;
  logic [7:0]         y_sharp;

  always_comb begin
    if (kernel_select) begin
      ksum = 13'sd9 * $signed({5'b0, lw[4]})
           - $signed({5'b0, lw[0]}) - $signed({5'b0, lw[1]}) - $signed({5'b0, lw[2]})
           - $signed({5'b0, lw[3]}) - $signed({5'b0, lw[5]})
           - $signed({5'b0, lw[6]}) - $signed({5'b0, lw[7]}) - $signed({5'b0, lw[8]});
    end else begin
      ksum = 13'sd5 * $signed({5'b0, lw[4]})
           - $signed({5'b0, lw[1]}) - $signed({5'b0, lw[3]})
           - $signed({5'b0, lw[5]}) - $signed({5'b0, lw[7]});
    end
    if (ksum < 13'sd0) begin
      y_sharp = 8'd0;
    end else if (ksum > 13'sd255) begin
      y_sharp = 8'd255;
    end else begin
      y_sharp = ksum[7:0];
    end
  end

  // stage 3: chroma differences
  logic [23:0] s3_rgb;
  logic [7:0]  s3_y;
  logic        s3_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_rgb <= s2_rgb;
      s3_y   <= s2_border ? s2_y : y_sharp;
      s3_fe  <= s2_fe;
    end
  end

  logic signed [26:0] dcb, dcr;
  logic signed [26:0] rs, gs, bs;

  always_comb begin
    rs  = $signed({19'b0, s3_rgb[23:16]});
    gs  = $signed({19'b0, s3_rgb[15:8]});
    bs  = $signed({19'b0, s3_rgb[7:0]});
    dcb = -27'sd11056 * rs - 27'sd21712 * gs + 27'sd32768 * bs;
    dcr =  27'sd32768 * rs - 27'sd27420 * gs - 27'sd5348 * bs;
  end

  // stage 4: q32 products
  logic signed [26:0] s4_dcb, s4_dcr;
  logic [7:0]         s4_y;
  logic               s4_fe;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_dcb <= dcb;
      s4_dcr <= dcr;
      s4_y   <= s3_y;
      s4_fe  <= s3_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  logic signed [46:0] pr, pg, pb;

  always_comb begin
    pr = 47'(CR_TO_R) * 47'(s4_dcr);
    pg = 47'(CB_TO_G) * 47'(s4_dcb) + 47'(CR_TO_G) * 47'(s4_dcr);
    pb = 47'(CB_TO_B) * 47'(s4_dcb);
  end

  logic signed [46:0] s5_pr, s5_pg, s5_pb;
  logic [7:0]         s5_y;
  logic               s5_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_pr <= pr;
      s5_pg <= pg;
      s5_pb <= pb;
      s5_y  <= s4_y;
      s5_fe <= s4_fe;
    end
  end

  // q32 to integer, rounding toward zero
  function automatic logic signed [12:0] trunc_q32(input logic signed [46:0] v);
    logic [46:0] mag;
    logic [12:0] q;
    mag = v[46] ? 47'(-v) : 47'(v);
    q   = {1'b0, mag[43:32]};
    return v[46] ? $signed(-q) : $signed(q);
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [13:0] v);
    if (v < 14'sd0) begin
      return 8'd0;
    end else if (v > 14'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  // output register
  logic signed [13:0] y14;
  assign y14 = $signed({6'b0, s5_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_ready) begin
      dst_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      dst_word.red_out   <= clamp8(y14 + 14'(trunc_q32(s5_pr)));
      dst_word.green_out <= clamp8(y14 - 14'(trunc_q32(s5_pg)));
      dst_word.blue_out  <= clamp8(y14 + 14'(trunc_q32(s5_pb)));
      dst_word.frame_end <= s5_fe;
    end
  end

`ifndef SYNTHESIS
  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    !done |-> row < h_eff)
    else $error("row counter ran past the frame height");

  a_flush_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (acc && real_in && !is_pix_in && flush_end && !cfg_write) |=>
      (!done && col == '0 && row == 12'd0 && !fstarted))
    else $error("last flush word did not restart the frame");

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    (acc && !mem_we) |=> !fwd)
    else $error("line forward set without a write ahead");
`endif

endmodule

`default_nettype wire
